// ----- rtl/core/cpsw_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsw_pkg
// Shared types and constants of the convex polygon span walker.
// ----------------------------------------------------------------------------
package cpsw_pkg;

    localparam int MAX_VERTICES = 5;
    localparam int FRAC_BITS    = 16;
    localparam int GUARD_SLACK  = 8;
    localparam logic [29:0] STEP_LIMIT = 30'h3FFF_FFFF;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_ROW    = 2'd2;

    localparam logic [1:0] CFG_VIEW_TOP    = 2'd0;
    localparam logic [1:0] CFG_VIEW_BOTTOM = 2'd1;
    localparam logic [1:0] CFG_CLIP_LEFT   = 2'd2;
    localparam logic [1:0] CFG_CLIP_RIGHT  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] vertex_col;
        logic signed [15:0] vertex_row;
    } span_in_t;

    typedef struct packed {
        logic [11:0] span_row;
        logic [11:0] span_left;
        logic [11:0] span_right;
        logic        span_drawn;
        logic        polygon_done;
    } span_out_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_RIGHT,
        RD_LEFT
    } rd_sel_t;

    typedef struct packed {
        logic    load_first;
        logic    load_append;
        logic    scan_init;
        logic    scan_step;
        logic    setup_commit;
        logic    guard_dec;
        logic    r_adv;
        logic    l_adv;
        logic    r_edge_start;
        logic    l_edge_start;
        logic    r_step_load;
        logic    l_step_load;
        logic    stop_first;
        logic    stop_decide;
        logic    mul_left;
        logic    mul_right;
        logic    add_right;
        logic    span_emit;
        logic    done_emit;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic store_full;
        logic scan_more;
        logic top_below;
        logic guard_out;
        logic row_match;
        logic idx_equal;
        logic div_busy;
        logic need_mul;
        logic seg_open;
        logic at_bot;
    } dp_status_t;

endpackage

// ----- rtl/core/cpsw_div.sv -----
// ----------------------------------------------------------------------------
// cpsw_div
// Edge slope divider: (dx << FRAC_BITS) / dy, truncated toward zero,
// saturated to +-STEP_LIMIT. Restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpsw_div #(
    parameter int FRAC_BITS = cpsw_pkg::FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    output logic               busy,
    output logic [31:0]        quotient
);

    localparam int NW = 16 + FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            neg_reg;
    logic [15:0]     den_reg;
    logic [15:0]     rem_reg;
    logic [NW-1:0]   quo_reg;

    logic [16:0] dx_abs, dy_abs;
    logic [16:0] rem_sh;
    logic [17:0] diff;
    logic [32:0] q_ext;
    logic [29:0] q_sat;
    logic [31:0] q_mag;

    assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
    assign dy_abs = dy[16] ? 17'(-dy) : 17'(dy);
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dx[16] ^ dy[16];
            den_reg <= dy_abs[15:0];
            rem_reg <= '0;
            quo_reg <= {dx_abs[15:0], {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_reg <= diff[15:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[15:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign q_ext    = 33'(quo_reg);
    assign q_sat    = (q_ext > 33'(cpsw_pkg::STEP_LIMIT)) ? cpsw_pkg::STEP_LIMIT : q_ext[29:0];
    assign q_mag    = {2'b00, q_sat};
    assign quotient = neg_reg ? (32'd0 - q_mag) : q_mag;
    assign busy     = busy_reg;

endmodule

// ----- rtl/core/cpsw_dp.sv -----
// ----------------------------------------------------------------------------
// cpsw_dp
// Datapath: vertex store, edge walkers, row counter, config registers and
// the result register.
// ----------------------------------------------------------------------------
module cpsw_dp #(
    parameter int MAX_VERTICES = cpsw_pkg::MAX_VERTICES,
    parameter int FRAC_BITS    = cpsw_pkg::FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpsw_pkg::span_in_t   req_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data,
    input  cpsw_pkg::dp_cmd_t    cmd,
    output cpsw_pkg::dp_status_t status,
    output cpsw_pkg::span_out_t  span_data
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [11:0] top_reg, bot_reg, cl_reg, cr_reg;

    logic signed [15:0] vcol_reg [MAX_VERTICES];
    logic signed [15:0] vrow_reg [MAX_VERTICES];
    logic [CW-1:0]      count_reg;

    logic [CW-1:0]      scan_reg;
    logic [IW-1:0]      best_idx_reg;
    logic signed [15:0] best_row_reg;

    logic [IW-1:0]      l_reg, r_reg;
    logic [31:0]        lpos_reg, rpos_reg, lstep_reg, rstep_reg;
    logic signed [15:0] cur_reg, seg_reg, stop_reg, oldx_reg;
    logic signed [15:0] guard_reg;
    logic signed [16:0] cnt_reg;
    logic [31:0]        prod_reg;
    cpsw_pkg::span_out_t out_reg;

    logic [IW-1:0]      rd_addr;
    logic signed [15:0] rd_row, rd_col;
    logic [CW-1:0]      r_inc;
    logic [IW-1:0]      r_next, l_next;
    logic signed [16:0] cur17, top17, bot17, stop17, seg_min;
    logic signed [15:0] stop_min;
    logic signed [48:0] mul_full;
    logic [31:0]        mul_a;
    logic               div_start, div_busy;
    logic [31:0]        div_q;
    logic signed [16:0] div_dx, div_dy;
    logic signed [32:0] xl, xr, x1c, x2c, cl33, cr33;
    logic               drawn;

    always_comb
    begin
        case (cmd.rd_sel)
            cpsw_pkg::RD_SCAN:  rd_addr = scan_reg[IW-1:0];
            cpsw_pkg::RD_RIGHT: rd_addr = r_reg;
            cpsw_pkg::RD_LEFT:  rd_addr = l_reg;
            default:            rd_addr = r_reg;
        endcase
    end

    assign rd_row = vrow_reg[rd_addr];
    assign rd_col = vcol_reg[rd_addr];

    assign r_inc  = CW'(r_reg) + 1'b1;
    assign r_next = (r_inc >= count_reg) ? '0 : r_inc[IW-1:0];
    assign l_next = (l_reg == '0) ? IW'(count_reg - 1'b1) : l_reg - 1'b1;

    assign cur17    = 17'(cur_reg);
    assign top17    = {5'd0, top_reg};
    assign bot17    = {5'd0, bot_reg};
    assign stop_min = (stop_reg < rd_row) ? stop_reg : rd_row;
    assign stop17   = 17'(stop_min);
    assign seg_min  = (stop17 > bot17) ? bot17 : stop17;

    assign div_start = cmd.r_edge_start | cmd.l_edge_start;
    assign div_dx    = 17'(rd_col) - 17'(oldx_reg);
    assign div_dy    = 17'(rd_row) - cur17;

    cpsw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dx       (div_dx),
        .dy       (div_dy),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // shared multiplier for skipping rows above the view
    assign mul_a    = cmd.mul_left ? lstep_reg : rstep_reg;
    assign mul_full = $signed({{17{mul_a[31]}}, mul_a}) * 49'(cnt_reg);

    // span columns, floor of the 16.16 edge positions
    assign xl   = 33'($signed(lpos_reg) >>> FRAC_BITS);
    assign xr   = 33'($signed(rpos_reg) >>> FRAC_BITS);
    assign cl33 = {21'd0, cl_reg};
    assign cr33 = {21'd0, cr_reg};
    assign x1c  = (xl < cl33) ? cl33 : xl;
    assign x2c  = (xr > cr33) ? cr33 : xr;
    assign drawn = (x1c < cr33) && (x2c > x1c);

    function automatic logic [11:0] sat12(input logic signed [32:0] v);
        logic [11:0] r;
        if (v < 0)
            r = 12'd0;
        else if (v > 33'sd4095)
            r = 12'hFFF;
        else
            r = v[11:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= 12'd0;
            bot_reg   <= 12'd200;
            cl_reg    <= 12'd0;
            cr_reg    <= 12'd320;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cpsw_pkg::CFG_VIEW_TOP:    top_reg <= cfg_data;
                    cpsw_pkg::CFG_VIEW_BOTTOM: bot_reg <= cfg_data;
                    cpsw_pkg::CFG_CLIP_LEFT:   cl_reg  <= cfg_data;
                    cpsw_pkg::CFG_CLIP_RIGHT:  cr_reg  <= cfg_data;
                    default:                   top_reg <= top_reg;
                endcase
            end
            if (cmd.load_first)
                count_reg <= CW'(1);
            else if (cmd.load_append)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            vcol_reg[0] <= req_data.vertex_col;
            vrow_reg[0] <= req_data.vertex_row;
        end
        else if (cmd.load_append)
        begin
            vcol_reg[count_reg[IW-1:0]] <= req_data.vertex_col;
            vrow_reg[count_reg[IW-1:0]] <= req_data.vertex_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_reg     <= CW'(1);
            best_idx_reg <= '0;
            best_row_reg <= vrow_reg[0];
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (rd_row < best_row_reg)
            begin
                best_idx_reg <= scan_reg[IW-1:0];
                best_row_reg <= rd_row;
            end
        end

        if (cmd.setup_commit)
        begin
            cur_reg   <= best_row_reg;
            seg_reg   <= best_row_reg;
            l_reg     <= best_idx_reg;
            r_reg     <= best_idx_reg;
            guard_reg <= 16'({count_reg, 1'b0}) + 16'(bot_reg) - 16'(top_reg)
                         + 16'(cpsw_pkg::GUARD_SLACK);
        end

        if (cmd.guard_dec)
            guard_reg <= guard_reg - 16'sd1;

        if (cmd.r_adv)
        begin
            oldx_reg <= rd_col;
            r_reg    <= r_next;
        end
        if (cmd.l_adv)
        begin
            oldx_reg <= rd_col;
            l_reg    <= l_next;
        end
        if (cmd.r_edge_start)
            rpos_reg <= 32'(oldx_reg) << FRAC_BITS;
        if (cmd.l_edge_start)
            lpos_reg <= 32'(oldx_reg) << FRAC_BITS;
        if (cmd.r_step_load)
            rstep_reg <= div_q;
        if (cmd.l_step_load)
            lstep_reg <= div_q;

        if (cmd.stop_first)
            stop_reg <= rd_row;

        if (cmd.stop_decide)
        begin
            if (stop17 <= top17)
            begin
                cnt_reg <= stop17 - cur17;
                cur_reg <= stop_min;
                seg_reg <= stop_min;
            end
            else if (cur17 < top17)
            begin
                cnt_reg <= top17 - cur17;
                cur_reg <= 16'(top_reg);
                seg_reg <= seg_min[15:0];
            end
            else
            begin
                seg_reg <= seg_min[15:0];
            end
        end

        if (cmd.mul_left || cmd.mul_right)
            prod_reg <= mul_full[31:0];
        if (cmd.mul_right)
            lpos_reg <= lpos_reg + prod_reg;
        if (cmd.add_right)
            rpos_reg <= rpos_reg + prod_reg;

        if (cmd.span_emit)
        begin
            out_reg.span_row     <= cur_reg[11:0];
            out_reg.span_left    <= sat12(x1c);
            out_reg.span_right   <= sat12(x2c);
            out_reg.span_drawn   <= drawn;
            out_reg.polygon_done <= 1'b0;
            lpos_reg <= lpos_reg + lstep_reg;
            rpos_reg <= rpos_reg + rstep_reg;
            cur_reg  <= cur_reg + 16'sd1;
        end
        else if (cmd.done_emit)
        begin
            out_reg <= '{span_row: 12'd0, span_left: 12'd0, span_right: 12'd0,
                         span_drawn: 1'b0, polygon_done: 1'b1};
        end
    end

    assign status.store_full = (count_reg == CW'(MAX_VERTICES));
    assign status.scan_more  = (scan_reg < count_reg);
    assign status.top_below  = (17'(best_row_reg) >= bot17);
    assign status.guard_out  = (guard_reg < 16'sd1);
    assign status.row_match  = (rd_row == cur_reg);
    assign status.idx_equal  = (l_reg == r_reg);
    assign status.div_busy   = div_busy;
    assign status.need_mul   = (stop17 <= top17) || (cur17 < top17);
    assign status.seg_open   = (cur_reg < seg_reg);
    assign status.at_bot     = (cur17 == bot17);

    assign span_data = out_reg;

endmodule

// ----- rtl/core/cpsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpsw_ctrl
// Controller: request decode, setup scan, edge walk sequencing, result beat.
// ----------------------------------------------------------------------------
module cpsw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           req_action,
    output logic                 span_valid,
    input  logic                 span_ready,
    input  cpsw_pkg::dp_status_t status,
    output cpsw_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        PH_DONE,
        PH_LOAD,
        PH_WALK
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_WALK,
        S_R_ADV,
        S_R_TEST,
        S_R_DIV,
        S_L_CHECK,
        S_L_ADV,
        S_L_TEST,
        S_L_DIV,
        S_STOP_R,
        S_STOP_L,
        S_MUL_L,
        S_MUL_R,
        S_ADD_R,
        S_CHECK,
        S_EMIT_SPAN,
        S_EMIT_DONE
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   valid_reg, valid_next;
    logic   can_out;

    assign can_out = !valid_reg || span_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = cpsw_pkg::RD_RIGHT;
        state_next = state_reg;
        phase_next = phase_reg;
        req_ready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (req_action)
                        cpsw_pkg::ACT_START:
                        begin
                            cmd.load_first = 1'b1;
                            phase_next     = PH_LOAD;
                        end
                        cpsw_pkg::ACT_APPEND:
                        begin
                            cmd.load_append = (phase_reg == PH_LOAD) && !status.store_full;
                        end
                        cpsw_pkg::ACT_ROW:
                        begin
                            if (phase_reg == PH_LOAD)
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                            else if (phase_reg == PH_WALK)
                                state_next = S_CHECK;
                            else
                                state_next = S_EMIT_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.rd_sel = cpsw_pkg::RD_SCAN;
                if (status.scan_more)
                    cmd.scan_step = 1'b1;
                else
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.setup_commit = 1'b1;
                if (status.top_below)
                begin
                    phase_next = PH_DONE;
                    state_next = S_EMIT_DONE;
                end
                else
                begin
                    phase_next = PH_WALK;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.guard_dec = 1'b1;
                if (status.guard_out)
                begin
                    phase_next = PH_DONE;
                    state_next = S_EMIT_DONE;
                end
                else if (status.row_match)
                    state_next = S_R_ADV;
                else
                    state_next = S_L_CHECK;
            end
            S_R_ADV:
            begin
                cmd.r_adv  = 1'b1;
                state_next = S_R_TEST;
            end
            S_R_TEST:
            begin
                if (!status.row_match)
                begin
                    cmd.r_edge_start = 1'b1;
                    state_next       = S_R_DIV;
                end
                else if (status.idx_equal)
                begin
                    phase_next = PH_DONE;
                    state_next = S_EMIT_DONE;
                end
                else
                    state_next = S_R_ADV;
            end
            S_R_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.r_step_load = 1'b1;
                    state_next      = S_L_CHECK;
                end
            end
            S_L_CHECK:
            begin
                cmd.rd_sel = cpsw_pkg::RD_LEFT;
                state_next = status.row_match ? S_L_ADV : S_STOP_R;
            end
            S_L_ADV:
            begin
                cmd.rd_sel = cpsw_pkg::RD_LEFT;
                cmd.l_adv  = 1'b1;
                state_next = S_L_TEST;
            end
            S_L_TEST:
            begin
                cmd.rd_sel = cpsw_pkg::RD_LEFT;
                if (!status.row_match)
                begin
                    cmd.l_edge_start = 1'b1;
                    state_next       = S_L_DIV;
                end
                else if (status.idx_equal)
                begin
                    phase_next = PH_DONE;
                    state_next = S_EMIT_DONE;
                end
                else
                    state_next = S_L_ADV;
            end
            S_L_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.l_step_load = 1'b1;
                    state_next      = S_STOP_R;
                end
            end
            S_STOP_R:
            begin
                cmd.stop_first = 1'b1;
                state_next     = S_STOP_L;
            end
            S_STOP_L:
            begin
                cmd.rd_sel      = cpsw_pkg::RD_LEFT;
                cmd.stop_decide = 1'b1;
                state_next      = status.need_mul ? S_MUL_L : S_CHECK;
            end
            S_MUL_L:
            begin
                cmd.mul_left = 1'b1;
                state_next   = S_MUL_R;
            end
            S_MUL_R:
            begin
                cmd.mul_right = 1'b1;
                state_next    = S_ADD_R;
            end
            S_ADD_R:
            begin
                cmd.add_right = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.seg_open)
                    state_next = S_EMIT_SPAN;
                else if (status.idx_equal || status.at_bot)
                begin
                    phase_next = PH_DONE;
                    state_next = S_EMIT_DONE;
                end
                else
                    state_next = S_WALK;
            end
            S_EMIT_SPAN:
            begin
                if (can_out)
                begin
                    cmd.span_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_DONE:
            begin
                if (can_out)
                begin
                    cmd.done_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.span_emit || cmd.done_emit)
            valid_next = 1'b1;
        else if (span_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DONE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign span_valid = valid_reg;

endmodule

// ----- rtl/core/convex_polygon_span_walker_core.sv -----
// ----------------------------------------------------------------------------
// convex_polygon_span_walker_core
// Turns a loaded clockwise convex polygon into one clamped span per request.
// ----------------------------------------------------------------------------
//  channel | signals                              | dir | beat
//  req     | req_valid req_ready req_data         | in  | vertex load or row request
//  span    | span_valid span_ready span_data      | out | one per row request
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data| in | register write, always ready
//
//  Vertex loads are stored on accept. A row request inside a segment: accept,
//  segment check, emit. Crossing a vertex adds walk, advance, test, check and
//  stop steps, another advance and test per horizontal edge skipped, multiply
//  and add steps when rows above the view are skipped, a wait per slope divide;
//  the first request also scans the store, one entry a cycle, then commits.
//  Reset is asynchronous, active low; the vertex store is not cleared.
//  A held span beat stalls only the emit step; req is taken again once the
//  result is in the output register.
module convex_polygon_span_walker_core #(
    parameter int MAX_VERTICES = cpsw_pkg::MAX_VERTICES,
    parameter int FRAC_BITS    = cpsw_pkg::FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  cpsw_pkg::span_in_t  req_data,
    output logic                span_valid,
    input  logic                span_ready,
    output cpsw_pkg::span_out_t span_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_data
);

    cpsw_pkg::dp_cmd_t    cmd;
    cpsw_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    cpsw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_action (req_data.action),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .status     (status),
        .cmd        (cmd)
    );

    cpsw_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .span_data (span_data)
    );

endmodule

// ----- rtl/core/cpsw_checker.sv -----
// ----------------------------------------------------------------------------
// cpsw_checker
// Port-level checks of the span walker, bound to the top level.
// ----------------------------------------------------------------------------
module cpsw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input cpsw_pkg::span_in_t  req_data,
    input logic                span_valid,
    input logic                span_ready,
    input cpsw_pkg::span_out_t span_data
);

    // a held result beat keeps its payload
    a_span_hold: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !span_ready |=> span_valid && $stable(span_data))
        else $error("span beat dropped or changed while stalled");

    // loads and unused codes never produce a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.action != cpsw_pkg::ACT_ROW)
        && !span_valid |=> !span_valid)
        else $error("result without a row request");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && span_data.polygon_done |->
        span_data.span_row == 12'd0 && span_data.span_left == 12'd0 &&
        span_data.span_right == 12'd0 && !span_data.span_drawn)
        else $error("done beat carries span fields");

    a_drawn_order: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && span_data.span_drawn |->
        !span_data.polygon_done && span_data.span_right > span_data.span_left)
        else $error("drawn span with right not past left");

endmodule

bind convex_polygon_span_walker_core cpsw_checker u_cpsw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span_data  (span_data)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of convex_polygon_span_walker_core. A short table of directed
// beats is followed by random convex polygons and random noise. Every row
// request is checked field by field against a typed table beat or a behavioral
// span predictor that runs beside the block, over several view and clip settings.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1250;

    typedef enum int { WALK_DONE, WALK_LOAD, WALK_RUN } walk_phase_t;

    typedef struct {
        logic [1:0]          act;
        int                  col;
        int                  row;
        bit                  typed;
        cpsw_pkg::span_out_t want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    cpsw_pkg::span_in_t  req_data;
    logic                span_valid;
    logic                span_ready;
    cpsw_pkg::span_out_t span_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [11:0]         cfg_data;

    convex_polygon_span_walker_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span_data  (span_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predictor state
    logic [11:0] view_top, view_bot, clip_lo, clip_hi;
    int          vtx_col [cpsw_pkg::MAX_VERTICES];
    int          vtx_row [cpsw_pkg::MAX_VERTICES];
    int          vtx_count, lft_idx, rgt_idx, cur_row, seg_stop, guard_left;
    logic [31:0] lft_pos, rgt_pos, lft_step, rgt_step;
    walk_phase_t walk_phase;

    cpsw_pkg::span_out_t span_expect_q[$];
    int          errors;
    int          items_sent;
    bit          calm;
    bit          hold_req;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] edge_slope(int dx, int dy);
        longint s;
        s = (longint'(dx) * 65536) / longint'(dy);
        if (s > 64'sh3FFF_FFFF) s = 64'sh3FFF_FFFF;
        if (s < -64'sh3FFF_FFFF) s = -64'sh3FFF_FFFF;
        return s[31:0];
    endfunction

    function automatic logic [11:0] clamp12(longint v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'hFFF;
        return v[11:0];
    endfunction

    // one pass over vertex crossings; 0 ends the walk
    function automatic bit cross_vertex();
        int oldx, dy, stp, top, bot, n;
        n   = vtx_count;
        top = int'(view_top);
        bot = int'(view_bot);
        guard_left--;
        if (guard_left < 0) return 0;
        if (cur_row == vtx_row[rgt_idx])
        begin
            do
            begin
                oldx    = vtx_col[rgt_idx];
                rgt_idx = (rgt_idx + 1 >= n) ? 0 : rgt_idx + 1;
                dy      = vtx_row[rgt_idx] - cur_row;
                if (dy == 0 && lft_idx == rgt_idx) return 0;
            end
            while (dy == 0);
            rgt_pos  = 32'(oldx) << cpsw_pkg::FRAC_BITS;
            rgt_step = edge_slope(vtx_col[rgt_idx] - oldx, dy);
        end
        if (cur_row == vtx_row[lft_idx])
        begin
            do
            begin
                oldx    = vtx_col[lft_idx];
                lft_idx = (lft_idx - 1 < 0) ? n - 1 : lft_idx - 1;
                dy      = vtx_row[lft_idx] - cur_row;
                if (dy == 0 && lft_idx == rgt_idx) return 0;
            end
            while (dy == 0);
            lft_pos  = 32'(oldx) << cpsw_pkg::FRAC_BITS;
            lft_step = edge_slope(vtx_col[lft_idx] - oldx, dy);
        end
        stp = (vtx_row[rgt_idx] < vtx_row[lft_idx]) ? vtx_row[rgt_idx] : vtx_row[lft_idx];
        if (stp <= top)
        begin
            lft_pos += lft_step * 32'(stp - cur_row);
            rgt_pos += rgt_step * 32'(stp - cur_row);
            cur_row  = stp;
            seg_stop = stp;
            return 1;
        end
        if (cur_row < top)
        begin
            lft_pos += lft_step * 32'(top - cur_row);
            rgt_pos += rgt_step * 32'(top - cur_row);
            cur_row  = top;
        end
        if (stp > bot) stp = bot;
        seg_stop = stp;
        return 1;
    endfunction

    function automatic bit start_walk();
        int t;
        t = 0;
        for (int i = 1; i < vtx_count; i++)
            if (vtx_row[i] < vtx_row[t]) t = i;
        cur_row  = vtx_row[t];
        lft_idx  = t;
        rgt_idx  = t;
        seg_stop = cur_row;
        if (cur_row >= int'(view_bot)) return 0;
        guard_left = 2 * vtx_count + (int'(view_bot) - int'(view_top))
                     + cpsw_pkg::GUARD_SLACK;
        return cross_vertex();
    endfunction

    function automatic void next_span(output cpsw_pkg::span_out_t r);
        longint x1, x2;
        r = '0;
        r.polygon_done = 1'b1;
        if (walk_phase == WALK_LOAD)
        begin
            if (!start_walk())
            begin
                walk_phase = WALK_DONE;
                return;
            end
            walk_phase = WALK_RUN;
        end
        if (walk_phase != WALK_RUN) return;
        while (1)
        begin
            if (cur_row < seg_stop)
            begin
                x1 = longint'($signed(lft_pos) >>> cpsw_pkg::FRAC_BITS);
                x2 = longint'($signed(rgt_pos) >>> cpsw_pkg::FRAC_BITS);
                if (x1 < longint'(clip_lo)) x1 = clip_lo;
                if (x2 > longint'(clip_hi)) x2 = clip_hi;
                r.span_row     = cur_row[11:0];
                r.span_left    = clamp12(x1);
                r.span_right   = clamp12(x2);
                r.span_drawn   = (x1 < longint'(clip_hi)) && (x2 > x1);
                r.polygon_done = 1'b0;
                lft_pos += lft_step;
                rgt_pos += rgt_step;
                cur_row++;
                return;
            end
            if (rgt_idx == lft_idx || cur_row == int'(view_bot) || !cross_vertex())
            begin
                walk_phase = WALK_DONE;
                return;
            end
        end
    endfunction

    // returns 1 when the beat yields a span result
    function automatic bit apply_req(cpsw_pkg::span_in_t d, output cpsw_pkg::span_out_t r);
        r = '0;
        case (d.action)
            cpsw_pkg::ACT_START:
            begin
                vtx_col[0] = d.vertex_col;
                vtx_row[0] = d.vertex_row;
                vtx_count  = 1;
                walk_phase = WALK_LOAD;
                return 0;
            end
            cpsw_pkg::ACT_APPEND:
            begin
                if (walk_phase == WALK_LOAD && vtx_count < cpsw_pkg::MAX_VERTICES)
                begin
                    vtx_col[vtx_count] = d.vertex_col;
                    vtx_row[vtx_count] = d.vertex_row;
                    vtx_count++;
                end
                return 0;
            end
            cpsw_pkg::ACT_ROW:
            begin
                next_span(r);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic cpsw_pkg::span_in_t mk_req(logic [1:0] act, int col, int row);
        cpsw_pkg::span_in_t d;
        d.action     = act;
        d.vertex_col = col[15:0];
        d.vertex_row = row[15:0];
        return d;
    endfunction

    task automatic put_req(cpsw_pkg::span_in_t d, bit typed = 0,
                           cpsw_pkg::span_out_t want = '0);
        int gap;
        cpsw_pkg::span_out_t r;
        gap = (calm || $urandom_range(99) >= 21) ? 0 : $urandom_range(1, 4);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= d;
        do @(posedge clk); while (!req_ready);
        items_sent++;
        if (apply_req(d, r))
            span_expect_q.push_back(typed ? want : r);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (span_expect_q.size() != 0) @(posedge clk);
        // a trailing vertex load may still be in flight
        repeat (60) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[11:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            cpsw_pkg::CFG_VIEW_TOP:    view_top = val[11:0];
            cpsw_pkg::CFG_VIEW_BOTTOM: view_bot = val[11:0];
            cpsw_pkg::CFG_CLIP_LEFT:   clip_lo  = val[11:0];
            default:                   clip_hi  = val[11:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(int top, int bot, int lo, int hi);
        drain();
        set_reg(cpsw_pkg::CFG_VIEW_TOP, top);
        set_reg(cpsw_pkg::CFG_VIEW_BOTTOM, bot);
        set_reg(cpsw_pkg::CFG_CLIP_LEFT, lo);
        set_reg(cpsw_pkg::CFG_CLIP_RIGHT, hi);
    endtask

    // clockwise convex polygon on screen (rows grow downward)
    task automatic send_polygon(int cx, int cy, int rad, int k, int rows);
        real a0, a;
        a0 = $urandom_range(0, 359) * 3.14159265 / 180.0;
        for (int i = 0; i < k; i++)
        begin
            a = a0 + 2.0 * 3.14159265 * (i + $urandom_range(0, 70) / 100.0) / k;
            put_req(mk_req(i == 0 ? cpsw_pkg::ACT_START : cpsw_pkg::ACT_APPEND,
                           cx + int'(rad * $cos(a)), cy + int'(rad * $sin(a))));
        end
        repeat (rows) put_req(mk_req(cpsw_pkg::ACT_ROW, 0, 0));
    endtask

    // broken sequences with full-range content
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        put_req(mk_req(cpsw_pkg::ACT_START, $urandom_range(0, 65535),
                       $urandom_range(0, 65535)));
        repeat (n)
            put_req(mk_req(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                           $urandom_range(0, 65535)));
        repeat ($urandom_range(1, 6)) put_req(mk_req(cpsw_pkg::ACT_ROW, 0, 0));
    endtask

    task automatic run_random(int upto, bit noise_ok);
        int cx, cy, rad, k;
        while (items_sent < upto)
        begin
            if (noise_ok && $urandom_range(99) < 15)
                send_noise();
            else
            begin
                rad = ($urandom_range(99) < 10) ? $urandom_range(20, 40) : $urandom_range(1, 20);
                k   = ($urandom_range(99) < 8) ? 6 : $urandom_range(3, cpsw_pkg::MAX_VERTICES);
                cx  = $urandom_range(0, int'(clip_hi) + 60) - 30;
                cy  = int'(view_top) - 25 + $urandom_range(0, int'(view_bot) - int'(view_top) + 50);
                if ($urandom_range(99) < 15)
                    put_req(mk_req(cpsw_pkg::ACT_APPEND, $urandom_range(0, 65535), 0));
                send_polygon(cx, cy, rad, k,
                             ($urandom_range(99) < 20) ? $urandom_range(1, rad)
                                                       : 2 * rad + $urandom_range(2, 5));
            end
        end
    endtask

    task automatic field_check(string name, int want, int got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cpsw_pkg::span_out_t want;
        if (rst_n && span_valid && span_ready)
        begin
            if (span_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected span beat, expected none, actual %h",
                         $time, span_data);
            end
            else
            begin
                want = span_expect_q.pop_front();
                field_check("span_row", int'(want.span_row), int'(span_data.span_row));
                field_check("span_left", int'(want.span_left), int'(span_data.span_left));
                field_check("span_right", int'(want.span_right), int'(span_data.span_right));
                field_check("span_drawn", int'(want.span_drawn), int'(span_data.span_drawn));
                field_check("polygon_done", int'(want.polygon_done),
                            int'(span_data.polygon_done));
            end
        end
    end

    initial
    begin
        span_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                span_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            span_ready <= (calm || $urandom_range(99) >= 21);
        end
    end

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        dir_row_t directed_tbl [0:25];
        directed_tbl = '{
            '{cpsw_pkg::ACT_ROW,    0,      0,      1, '{12'd0, 12'd0, 12'd0, 1'b0, 1'b1}},
            '{cpsw_pkg::ACT_APPEND, 5,      5,      0, '0},
            '{ACT_UNUSED,           -1,     -1,     0, '0},
            '{cpsw_pkg::ACT_START,  10,     10,     0, '0},
            '{cpsw_pkg::ACT_APPEND, 20,     20,     0, '0},
            '{cpsw_pkg::ACT_APPEND, 0,      20,     0, '0},
            '{cpsw_pkg::ACT_ROW,    0,      0,      1, '{12'd10, 12'd10, 12'd10, 1'b0, 1'b0}},
            '{cpsw_pkg::ACT_ROW,    0,      0,      0, '0},
            '{cpsw_pkg::ACT_START,  7,      7,      0, '0},
            '{cpsw_pkg::ACT_ROW,    0,      0,      1, '{12'd0, 12'd0, 12'd0, 1'b0, 1'b1}},
            '{cpsw_pkg::ACT_START,  0,      0,      0, '0},
            '{cpsw_pkg::ACT_APPEND, 4,      0,      0, '0},
            '{cpsw_pkg::ACT_APPEND, 4,      4,      0, '0},
            '{cpsw_pkg::ACT_APPEND, 0,      4,      0, '0},
            '{cpsw_pkg::ACT_APPEND, 2,      2,      0, '0},
            '{cpsw_pkg::ACT_APPEND, 9,      9,      0, '0},
            '{cpsw_pkg::ACT_ROW,    0,      0,      0, '0},
            '{cpsw_pkg::ACT_ROW,    0,      0,      0, '0},
            '{cpsw_pkg::ACT_START,  -32768, -32768, 0, '0},
            '{cpsw_pkg::ACT_APPEND, 32767,  -32768, 0, '0},
            '{cpsw_pkg::ACT_APPEND, 32767,  32767,  0, '0},
            '{cpsw_pkg::ACT_APPEND, -32768, 32767,  0, '0},
            '{cpsw_pkg::ACT_ROW,    0,      0,      1, '{12'd0, 12'd0, 12'd320, 1'b1, 1'b0}},
            '{cpsw_pkg::ACT_START,  5,      300,    0, '0},
            '{cpsw_pkg::ACT_APPEND, 9,      310,    0, '0},
            '{cpsw_pkg::ACT_ROW,    0,      0,      1, '{12'd0, 12'd0, 12'd0, 1'b0, 1'b1}}
        };
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = cpsw_pkg::CFG_VIEW_TOP;
        cfg_data   = '0;
        errors     = 0;
        items_sent = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        view_top   = 12'd0;
        view_bot   = 12'd200;
        clip_lo    = 12'd0;
        clip_hi    = 12'd320;
        vtx_count  = 0;
        lft_idx    = 0;
        rgt_idx    = 0;
        cur_row    = 0;
        seg_stop   = 0;
        guard_left = 0;
        lft_pos    = '0;
        rgt_pos    = '0;
        lft_step   = '0;
        rgt_step   = '0;
        walk_phase = WALK_DONE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_tbl[i])
            put_req(mk_req(directed_tbl[i].act, directed_tbl[i].col, directed_tbl[i].row),
                    directed_tbl[i].typed, directed_tbl[i].want);

        run_random(120, 1);
        // long receiver hold while a tall polygon keeps the request side busy
        hold_req = 1'b1;
        send_polygon(150, 100, 35, 5, 74);
        run_random(250, 1);

        set_view(0, 4095, 0, 4095);
        run_random(420, 0);

        set_view(4095, 0, 4095, 0);
        run_random(480, 1);

        set_view($urandom_range(0, 200), $urandom_range(150, 400),
                 $urandom_range(0, 300), $urandom_range(200, 600));
        calm = 1'b1;
        run_random(700, 1);
        calm = 1'b0;

        while (items_sent < TOTAL_ITEMS)
        begin
            set_view($urandom_range(0, 200), $urandom_range(0, 450),
                     $urandom_range(0, 300), $urandom_range(0, 600));
            run_random(items_sent + 180, 1);
        end

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && span_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/cpsw_pkg.sv
rtl/core/cpsw_div.sv
rtl/core/cpsw_dp.sv
rtl/core/cpsw_ctrl.sv
rtl/core/convex_polygon_span_walker_core.sv
rtl/core/cpsw_checker.sv
verif/tb.sv
